[src/bdre_pkg.sv]
// Shared types and constants for the battery drain rate estimator.
package bdre_pkg;

   localparam int REQUEST_PERIOD_DEFAULT = 10;
   localparam int PERCENT_W = 7;
   localparam int EST_W = 16;
   localparam int REMAIN_W = 23;
   localparam int RATE_W = 12;
   localparam int PHASE_W = 4;
   localparam int TRANS_W = 2;
   localparam int MUL_CNT_W = 3;
   localparam int DIV_CNT_W = 4;

   localparam logic [EST_W-1:0] EST_RESET = 16'd108;
   localparam logic [RATE_W-1:0] RATE_NUMERATOR = 12'd3600;
   localparam logic [TRANS_W-1:0] LATCH_AFTER = 2'd2;
   localparam logic [TRANS_W-1:0] TRANS_MAX = 2'd3;
   localparam logic [EST_W-1:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [PERCENT_W-1:0] battery_percent;
      logic lens_busy;
   } req_type;

   typedef struct packed {
      logic request_report;
      logic [REMAIN_W-1:0] seconds_remaining;
      logic [RATE_W-1:0] percent_per_hour;
   } rsp_type;

   typedef struct packed {
      logic request_report;
      logic [EST_W-1:0] estimate;
   } track_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage

[src/bdre_stream_if.sv]
// Valid/ready channel carrying one payload per transaction.
interface bdre_stream_if #(
   parameter type payload_type = logic
);
   logic valid;
   logic ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[src/bdre_track.sv]
// Level tracking, report phase and seconds-per-percent estimate state.
module bdre_track #(
   parameter int REQUEST_PERIOD = bdre_pkg::REQUEST_PERIOD_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic take,
   input logic [bdre_pkg::PERCENT_W-1:0] level,
   input logic busy,
   input logic csr_we,
   input logic [bdre_pkg::EST_W-1:0] csr_wdata,
   output bdre_pkg::track_type upd
);
   import bdre_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in, phase_inc;
   logic [PERCENT_W-1:0] prev_ff;
   logic prev_valid_ff;
   logic [EST_W-1:0] secs_ff, secs_in;
   logic [TRANS_W-1:0] trans_ff, trans_in;
   logic [EST_W-1:0] est_ff, est_in;
   logic same;

   always_comb begin
      phase_inc = phase_ff + PHASE_W'(1);
      phase_in = phase_inc;
      upd.request_report = 1'b0;
      if (phase_inc >= PHASE_W'(REQUEST_PERIOD)) begin
         phase_in = '0;
         upd.request_report = !busy;
      end
      same = prev_valid_ff && (level == prev_ff);
      trans_in = trans_ff;
      est_in = est_ff;
      if (same) begin
         secs_in = (secs_ff == COUNT_MAX) ? secs_ff : secs_ff + EST_W'(1);
      end else begin
         secs_in = '0;
         trans_in = (trans_ff == TRANS_MAX) ? trans_ff : trans_ff + TRANS_W'(1);
         if (trans_in > LATCH_AFTER) begin
            est_in = secs_ff;
         end
      end
      upd.estimate = est_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         prev_ff <= '0;
         prev_valid_ff <= 1'b0;
         secs_ff <= '0;
         trans_ff <= '0;
         est_ff <= EST_RESET;
      end else if (csr_we) begin
         est_ff <= csr_wdata;
      end else if (take) begin
         phase_ff <= phase_in;
         prev_ff <= level;
         prev_valid_ff <= 1'b1;
         secs_ff <= secs_in;
         trans_ff <= trans_in;
         est_ff <= est_in;
      end
   end
endmodule

[src/bdre_mul.sv]
// Bit-serial shift-add multiplier: estimate times level, one level bit per cycle.
module bdre_mul (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [bdre_pkg::EST_W-1:0] mcand,
   input logic [bdre_pkg::PERCENT_W-1:0] mplier,
   output logic done,
   output logic [bdre_pkg::REMAIN_W-1:0] product
);
   import bdre_pkg::*;

   logic [REMAIN_W-1:0] acc_ff, mcand_ff;
   logic [PERCENT_W-1:0] mplier_ff;
   logic [MUL_CNT_W-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= MUL_CNT_W'(PERCENT_W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - MUL_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         mcand_ff <= REMAIN_W'(mcand);
         mplier_ff <= mplier;
      end else if (cnt_ff != '0) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff <= {mcand_ff[REMAIN_W-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[PERCENT_W-1:1]};
      end
   end

   assign done = (cnt_ff == '0);
   assign product = acc_ff;
endmodule

[src/bdre_div.sv]
// Restoring divider: 3600 over the estimate, one quotient bit per cycle.
module bdre_div (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [bdre_pkg::EST_W-1:0] divisor,
   output logic done,
   output logic [bdre_pkg::RATE_W-1:0] quotient
);
   import bdre_pkg::*;

   logic [EST_W-1:0] rem_ff, div_ff;
   logic [RATE_W-1:0] quo_ff;
   logic zero_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [EST_W:0] trial, diff;

   always_comb begin
      trial = {rem_ff, quo_ff[RATE_W-1]};
      diff = trial - {1'b0, div_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= DIV_CNT_W'(RATE_W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         div_ff <= divisor;
         quo_ff <= RATE_NUMERATOR;
         zero_ff <= (divisor == '0);
      end else if (cnt_ff != '0) begin
         if (!diff[EST_W]) begin
            rem_ff <= diff[EST_W-1:0];
            quo_ff <= {quo_ff[RATE_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial[EST_W-1:0];
            quo_ff <= {quo_ff[RATE_W-2:0], 1'b0};
         end
      end
   end

   assign done = (cnt_ff == '0);
   assign quotient = zero_ff ? RATE_NUMERATOR : quo_ff;
endmodule

[src/battery_drain_rate_estimator_core.sv]
// Top level of the battery drain rate estimator.
//
//   channel | dir | transaction
//   req     | in  | battery_percent, lens_busy (one per second tick)
//   rsp     | out | request_report, seconds_remaining, percent_per_hour
//   csr     | in  | write of initial_seconds_per_percent (also loads estimate)
//
// A transaction runs accept, 12 divider steps (the serial divider bounds
// it; the 7-step multiplier runs alongside), collect, then the load of the
// output register, which waits while a held response is stalled. The output
// register lets the next request be accepted while a response is stalled.
// Synchronous reset restores the estimate to 108 and clears all counters.
module battery_drain_rate_estimator_core #(
   parameter int REQUEST_PERIOD = bdre_pkg::REQUEST_PERIOD_DEFAULT
) (
   input logic clock,
   input logic reset,
   bdre_stream_if.sink req,
   bdre_stream_if.source rsp,
   input logic csr_we,
   input logic [bdre_pkg::EST_W-1:0] csr_wdata
);
   import bdre_pkg::*;

   state_type state_ff, state_in;
   track_type upd;
   logic take;
   logic request_ff;
   logic mul_done, div_done;
   logic [REMAIN_W-1:0] product;
   logic [RATE_W-1:0] quotient;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic load_rsp;

   assign req.ready = (state_ff == ST_IDLE);
   assign take = req.valid && req.ready;

   bdre_track #(
      .REQUEST_PERIOD(REQUEST_PERIOD)
   ) u_track (
      .clock(clock),
      .reset(reset),
      .take(take),
      .level(req.payload.battery_percent),
      .busy(req.payload.lens_busy),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .upd(upd)
   );

   bdre_mul u_mul (
      .clock(clock),
      .reset(reset),
      .start(take),
      .mcand(upd.estimate),
      .mplier(req.payload.battery_percent),
      .done(mul_done),
      .product(product)
   );

   bdre_div u_div (
      .clock(clock),
      .reset(reset),
      .start(take),
      .divisor(upd.estimate),
      .done(div_done),
      .quotient(quotient)
   );

   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (mul_done && div_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load_rsp) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         request_ff <= upd.request_report;
      end
      if (load_rsp) begin
         rsp_data_ff.request_report <= request_ff;
         rsp_data_ff.seconds_remaining <= product;
         rsp_data_ff.percent_per_hour <= quotient;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;
endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Testbench for battery_drain_rate_estimator_core: directed table, long stay, random ticks.
module testbench;
   import bdre_pkg::*;

   typedef enum logic [0:0] {
      ROW_TICK,
      ROW_CSR
   } row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [PERCENT_W-1:0] level;
      logic busy;
      logic [EST_W-1:0] csr_value;
      bit typed;
      rsp_type result;
   } plan_row_type;

   localparam int LONG_STAY_TICKS = 120;
   localparam int RANDOM_PHASES = 10;
   localparam int TICKS_PER_PHASE = 100;

   logic clock;
   logic reset;
   logic csr_we;
   logic [EST_W-1:0] csr_wdata;

   bdre_stream_if #(.payload_type(req_type)) req_ch ();
   bdre_stream_if #(.payload_type(rsp_type)) rsp_ch ();

   battery_drain_rate_estimator_core dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   // predictor state
   logic [PHASE_W-1:0] phase_q;
   logic [PERCENT_W-1:0] last_level;
   bit level_seen;
   logic [EST_W-1:0] level_secs;
   logic [TRANS_W-1:0] change_count;
   logic [EST_W-1:0] est_secs;

   rsp_type forecast_q [$];
   rsp_type owed;
   int error_count;
   bit steady;
   int stall_left;
   plan_row_type directed_plan [28];

   always #5 clock = ~clock;

   function automatic rsp_type predict_drain(req_type item);
      rsp_type r;
      r.request_report = 1'b0;
      phase_q = phase_q + 1'b1;
      if (phase_q >= REQUEST_PERIOD_DEFAULT) begin
         phase_q = '0;
         r.request_report = !item.lens_busy;
      end
      if (level_seen && item.battery_percent == last_level) begin
         if (level_secs != COUNT_MAX) level_secs = level_secs + 1'b1;
      end else begin
         if (change_count != TRANS_MAX) change_count = change_count + 1'b1;
         if (change_count > LATCH_AFTER) est_secs = level_secs;
         level_secs = '0;
      end
      last_level = item.battery_percent;
      level_seen = 1'b1;
      r.seconds_remaining = est_secs * item.battery_percent;
      if (est_secs == 0) r.percent_per_hour = RATE_NUMERATOR;
      else r.percent_per_hour = RATE_W'(int'(RATE_NUMERATOR) / int'(est_secs));
      return r;
   endfunction

   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic flag_field(input string label, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d got %0d", $time, label, want, got);
         error_count++;
      end
   endtask

   task automatic send_tick(input req_type item, input bit use_typed, input rsp_type typed);
      rsp_type calc;
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.payload <= item;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      calc = predict_drain(item);
      forecast_q.push_back(use_typed ? typed : calc);
      gap = idle_span();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (forecast_q.size() != 0);
   endtask

   task automatic load_estimate(input logic [EST_W-1:0] value);
      hold_until_drained();
      repeat (16) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      est_secs = value;
   endtask

   // response side: random backpressure
   initial begin
      rsp_ch.ready = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = idle_span();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (forecast_q.size() == 0) begin
            $display("%0t: response transaction with none outstanding", $time);
            error_count++;
         end else begin
            owed = forecast_q.pop_front();
            flag_field("request_report", owed.request_report, rsp_ch.payload.request_report);
            flag_field("seconds_remaining", owed.seconds_remaining,
               rsp_ch.payload.seconds_remaining);
            flag_field("percent_per_hour", owed.percent_per_hour,
               rsp_ch.payload.percent_per_hour);
         end
      end
   end

   initial begin
      #50_000_000;
      $display("battery_drain_rate_estimator_core verification failed");
      $finish;
   end

   initial begin
      logic [PERCENT_W-1:0] level_now;
      logic [PERCENT_W-1:0] level_out;
      logic busy_out;
      logic [EST_W-1:0] csr_value;
      int run_left;
      int pick;

      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      error_count = 0;
      steady = 1'b0;
      phase_q = '0;
      last_level = '0;
      level_seen = 1'b0;
      level_secs = '0;
      change_count = '0;
      est_secs = EST_RESET;

      directed_plan = '{
         '{ROW_TICK, 7'd100, 1'b0, 16'd0, 1'b1, '{1'b0, 23'd10800, 12'd33}},
         '{ROW_TICK, 7'd0, 1'b1, 16'd0, 1'b1, '{1'b0, 23'd0, 12'd33}},
         '{ROW_TICK, 7'd127, 1'b0, 16'd0, 1'b1, '{1'b0, 23'd0, 12'd3600}},
         '{ROW_TICK, 7'd127, 1'b0, 16'd0, 1'b1, '{1'b0, 23'd0, 12'd3600}},
         '{ROW_TICK, 7'd127, 1'b1, 16'd0, 1'b1, '{1'b0, 23'd0, 12'd3600}},
         '{ROW_TICK, 7'd126, 1'b0, 16'd0, 1'b1, '{1'b0, 23'd252, 12'd1800}},
         '{ROW_TICK, 7'd126, 1'b0, 16'd0, 1'b1, '{1'b0, 23'd252, 12'd1800}},
         '{ROW_TICK, 7'd126, 1'b1, 16'd0, 1'b1, '{1'b0, 23'd252, 12'd1800}},
         '{ROW_TICK, 7'd126, 1'b0, 16'd0, 1'b1, '{1'b0, 23'd252, 12'd1800}},
         '{ROW_TICK, 7'd126, 1'b0, 16'd0, 1'b1, '{1'b1, 23'd252, 12'd1800}},
         '{ROW_CSR, 7'd0, 1'b0, 16'd65535, 1'b0, '0},
         '{ROW_TICK, 7'd126, 1'b0, 16'd0, 1'b1, '{1'b0, 23'd8257410, 12'd0}},
         '{ROW_TICK, 7'd127, 1'b1, 16'd0, 1'b0, '0},
         '{ROW_CSR, 7'd0, 1'b0, 16'd0, 1'b0, '0},
         '{ROW_TICK, 7'd127, 1'b0, 16'd0, 1'b0, '0},
         '{ROW_CSR, 7'd0, 1'b0, 16'd1, 1'b0, '0},
         '{ROW_TICK, 7'd127, 1'b1, 16'd0, 1'b0, '0},
         '{ROW_CSR, 7'd0, 1'b0, 16'd3600, 1'b0, '0},
         '{ROW_TICK, 7'd127, 1'b0, 16'd0, 1'b0, '0},
         '{ROW_CSR, 7'd0, 1'b0, 16'd3601, 1'b0, '0},
         '{ROW_TICK, 7'd127, 1'b0, 16'd0, 1'b0, '0},
         '{ROW_CSR, 7'd0, 1'b0, 16'd65535, 1'b0, '0},
         '{ROW_TICK, 7'd127, 1'b1, 16'd0, 1'b0, '0},
         '{ROW_CSR, 7'd0, 1'b0, 16'd108, 1'b0, '0},
         '{ROW_TICK, 7'd64, 1'b0, 16'd0, 1'b0, '0},
         '{ROW_TICK, 7'd64, 1'b1, 16'd0, 1'b0, '0},
         '{ROW_TICK, 7'd65, 1'b1, 16'd0, 1'b0, '0},
         '{ROW_TICK, 7'd1, 1'b0, 16'd0, 1'b0, '0}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_CSR) begin
            load_estimate(directed_plan[i].csr_value);
         end else begin
            send_tick('{directed_plan[i].level, directed_plan[i].busy},
               directed_plan[i].typed, directed_plan[i].result);
         end
      end

      // long stay at one level, then the seconds count latches as estimate
      steady = 1'b1;
      for (int n = 0; n < LONG_STAY_TICKS; n++) begin
         send_tick('{7'd50, 1'(n % 7 == 0)}, 1'b0, '0);
      end
      send_tick('{7'd49, 1'b0}, 1'b0, '0);
      send_tick('{7'd48, 1'b0}, 1'b0, '0);
      steady = 1'b0;

      level_now = 7'd100;
      run_left = 0;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: csr_value = 16'd0;
            1: csr_value = 16'hFFFF;
            2: csr_value = 16'd1;
            3: csr_value = 16'd3600;
            4: csr_value = 16'd3601;
            5: csr_value = EST_RESET;
            default: begin
               if ($urandom_range(0, 1) == 0) csr_value = EST_W'($urandom_range(1, 300));
               else csr_value = EST_W'($urandom_range(0, 65535));
            end
         endcase
         load_estimate(csr_value);
         steady = (p % 4 == 2);
         for (int n = 0; n < TICKS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
               if (run_left == 0) begin
                  if ($urandom_range(0, 4) == 0) level_now = level_now + 1'b1;
                  else level_now = level_now - 1'b1;
                  if ($urandom_range(0, 9) == 0) run_left = $urandom_range(40, 300);
                  else run_left = $urandom_range(0, 15);
               end else begin
                  run_left--;
               end
               level_out = level_now;
            end else if (pick < 95) begin
               level_now = PERCENT_W'($urandom_range(0, 127));
               level_out = level_now;
               run_left = $urandom_range(0, 15);
            end else begin
               level_out = PERCENT_W'($urandom_range(0, 127));
            end
            busy_out = ($urandom_range(0, 9) < 3);
            send_tick('{level_out, busy_out}, 1'b0, '0);
            if ($urandom_range(0, 199) == 0) hold_until_drained();
         end
      end

      hold_until_drained();
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("battery_drain_rate_estimator_core verification clean");
      end else begin
         $display("battery_drain_rate_estimator_core verification failed");
      end
      $finish;
   end

endmodule
